>>> rtl/vfc_pkg.sv
// shared types and constants for the view frustum cull test
`default_nettype none

package vfc_pkg;

    localparam int NUM_REGS    = 8;
    localparam int NUM_PLANES  = 6;
    localparam int REG_INDEX_W = 4;
    localparam int MAT_W       = 64;

    localparam logic [1:0] FUNC_SPHERE = 2'd1;
    localparam logic [1:0] FUNC_BOX    = 2'd2;

    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd2;

    typedef enum logic [2:0] {
        PL_IDLE,
        PL_SQ,
        PL_ROOT,
        PL_LOAD,
        PL_DIV
    } plane_state_t;

    typedef logic [NUM_REGS-1:0][MAT_W-1:0] matrix_t;

    typedef struct packed {
        logic                  busy;
        logic [NUM_PLANES-1:0] ok;
    } plane_status_t;

endpackage

`default_nettype wire

>>> rtl/vfc_planes.sv
// plane extraction and normalization sequencer
`default_nettype none

module vfc_planes
    import vfc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          restart,
    input  wire matrix_t       mat,
    output plane_status_t      status,
    output logic [NUM_PLANES-1:0][3:0][33+FRACTION_BITS-1:0] coef
);

    localparam int AW = 33 + FRACTION_BITS;
    localparam int NW = AW - 1;
    localparam int SW = $clog2(NW);

    plane_state_t state_reg, state_next;
    logic [2:0]    plane_reg;
    logic [1:0]    k_reg;
    logic [SW-1:0] step_reg;
    logic [63:0]   l2_reg;
    logic [63:0]   v_reg, r_reg, bit_reg;
    logic [31:0]   len_reg;
    logic [NW-1:0] num_reg;
    logic [31:0]   rem_reg;
    logic          neg_reg;
    logic [NUM_PLANES-1:0] ok_reg;
    logic [NUM_PLANES-1:0][3:0][AW-1:0] coef_reg;

    logic signed [32:0] e3, er, sum33, mag33;
    logic signed [31:0] c;
    logic [31:0]   mag;
    logic [63:0]   sq;
    logic [63:0]   trial, r_nx, v_nx;
    logic          root_ge;
    logic [32:0]   rem_sh;
    logic          div_ge;
    logic [31:0]   rem_nx;
    logic [NW-1:0] num_nx;
    logic [AW-1:0] q_ext, a_val;
    logic          sq_last, root_last, root_zero, div_last, plane_last;

    function automatic logic signed [31:0] elem(input matrix_t m, input logic [1:0] row,
                                                input logic [1:0] col);
        logic [63:0] w;
        begin
            w = m[{row, col[1]}];
            return col[0] ? w[63:32] : w[31:0];
        end
    endfunction

    // raw coefficient of the current plane, saturated to 32 bits
    always_comb
    begin
        e3    = 33'(elem(mat, 2'd3, k_reg));
        er    = 33'(elem(mat, plane_reg[2:1], k_reg));
        sum33 = plane_reg[0] ? e3 - er : e3 + er;
        if (sum33[32] != sum33[31])
            c = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            c = sum33[31:0];
        mag33 = c[31] ? -33'(c) : 33'(c);
        mag   = mag33[31:0];
        sq    = mag * mag;
    end

    // one root bit per cycle
    always_comb
    begin
        trial   = r_reg + bit_reg;
        root_ge = v_reg >= trial;
        r_nx    = root_ge ? (r_reg >> 1) + bit_reg : r_reg >> 1;
        v_nx    = root_ge ? v_reg - trial : v_reg;
    end

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NW-1]};
        div_ge = rem_sh >= {1'b0, len_reg};
        rem_nx = div_ge ? 32'(rem_sh - {1'b0, len_reg}) : rem_sh[31:0];
        num_nx = {num_reg[NW-2:0], div_ge};
        q_ext  = {1'b0, num_nx};
        a_val  = neg_reg ? -q_ext : q_ext;
    end

    always_comb
    begin
        sq_last    = (k_reg == 2'd2);
        root_last  = (step_reg == SW'(31));
        root_zero  = (r_nx[31:0] == 32'd0);
        div_last   = (step_reg == SW'(NW - 1));
        plane_last = (plane_reg == 3'(NUM_PLANES - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PL_IDLE:
                state_next = PL_IDLE;
            PL_SQ:
                if (sq_last)
                    state_next = PL_ROOT;
            PL_ROOT:
                if (root_last)
                begin
                    if (!root_zero)
                        state_next = PL_LOAD;
                    else
                        state_next = plane_last ? PL_IDLE : PL_SQ;
                end
            PL_LOAD:
                state_next = PL_DIV;
            PL_DIV:
                if (div_last)
                begin
                    if (k_reg != 2'd3)
                        state_next = PL_LOAD;
                    else
                        state_next = plane_last ? PL_IDLE : PL_SQ;
                end
            default:
                state_next = PL_IDLE;
        endcase
        if (restart)
            state_next = PL_SQ;
    end

    always_comb
    begin
        status.busy = (state_reg != PL_IDLE);
        status.ok   = ok_reg;
        coef        = coef_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PL_SQ;
            plane_reg <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            l2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                plane_reg <= '0;
                k_reg     <= '0;
                step_reg  <= '0;
                l2_reg    <= '0;
            end
            else
            begin
                case (state_reg)
                    PL_SQ:
                    begin
                        l2_reg <= l2_reg + sq;
                        k_reg  <= sq_last ? 2'd0 : k_reg + 2'd1;
                        step_reg <= '0;
                    end
                    PL_ROOT:
                    begin
                        step_reg <= root_last ? '0 : step_reg + SW'(1);
                        if (root_last && root_zero)
                        begin
                            plane_reg <= plane_reg + 3'd1;
                            l2_reg    <= '0;
                        end
                    end
                    PL_LOAD:
                        step_reg <= '0;
                    PL_DIV:
                    begin
                        step_reg <= div_last ? '0 : step_reg + SW'(1);
                        if (div_last)
                        begin
                            k_reg <= k_reg + 2'd1;
                            if (k_reg == 2'd3)
                            begin
                                plane_reg <= plane_reg + 3'd1;
                                l2_reg    <= '0;
                            end
                        end
                    end
                    default:
                        step_reg <= '0;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            PL_SQ:
                if (sq_last)
                begin
                    v_reg   <= l2_reg + sq;
                    r_reg   <= '0;
                    bit_reg <= 64'd1 << 62;
                end
            PL_ROOT:
            begin
                v_reg   <= v_nx;
                r_reg   <= r_nx;
                bit_reg <= bit_reg >> 2;
                if (root_last)
                begin
                    len_reg           <= r_nx[31:0];
                    ok_reg[plane_reg] <= !root_zero;
                    if (root_zero)
                        coef_reg[plane_reg] <= '0;
                end
            end
            PL_LOAD:
            begin
                num_reg <= NW'({mag, {FRACTION_BITS{1'b0}}}) + NW'(len_reg >> 1);
                neg_reg <= c[31];
                rem_reg <= '0;
            end
            PL_DIV:
            begin
                rem_reg <= rem_nx;
                num_reg <= num_nx;
                if (div_last)
                    coef_reg[plane_reg][k_reg] <= a_val;
            end
            default:
                neg_reg <= neg_reg;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/view_frustum_cull_test.sv
// view frustum cull test: six normalized planes tested against a point, sphere or box
// one transaction per cycle while the output is taken; the 18 products, their
// per-plane sums and the compares each have a stage of their own. after reset and
// after every register write the plane unit runs (sqrt and divider, one bit per
// cycle) with input stalled; registers reset to the identity matrix
`default_nettype none

module view_frustum_cull_test
    import vfc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [REG_INDEX_W-1:0] cfg_index,
    input  wire logic [MAT_W-1:0]       cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             func,
    input  wire logic signed [31:0]     center_x,
    input  wire logic signed [31:0]     center_y,
    input  wire logic signed [31:0]     center_z,
    input  wire logic [30:0]            radius,
    input  wire logic [30:0]            extent_x,
    input  wire logic [30:0]            extent_y,
    input  wire logic [30:0]            extent_z,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  verdict,
    output logic                        degenerate
);

    localparam int AW  = 33 + FRACTION_BITS;
    localparam int LW  = AW / 2;
    localparam int HW  = AW - LW;
    localparam int HPW = HW + 32;
    localparam int LPW = LW + 33;
    localparam int PW  = AW + 32;
    localparam int ACW = PW + 2;
    localparam int DW  = ACW - FRACTION_BITS + 1;

    // identity matrix, register 7 first
    localparam matrix_t MAT_RESET = {
        64'd1 << (32 + FRACTION_BITS), 64'd0,
        64'd1 << FRACTION_BITS,        64'd0,
        64'd0,                         64'd1 << (32 + FRACTION_BITS),
        64'd0,                         64'd1 << FRACTION_BITS
    };

    matrix_t       mat_reg;
    plane_status_t status;
    logic [NUM_PLANES-1:0][3:0][AW-1:0] coef;
    logic          cfg_hit;
    logic          en, accept;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic signed [31:0]  pt1_reg [3];
    logic                point1_reg, point2_reg, point3_reg, point4_reg;
    logic [30:0]         r1_reg, r2_reg, r3_reg, r4_reg;
    logic [30:0]         r_in, ext_max;
    logic signed [HPW-1:0] ph_c [NUM_PLANES][3];
    logic signed [LPW-1:0] pl_c [NUM_PLANES][3];
    logic signed [HPW-1:0] ph_reg [NUM_PLANES][3];
    logic signed [LPW-1:0] pl_reg [NUM_PLANES][3];
    logic signed [PW-1:0]  prod_reg [NUM_PLANES][3];
    logic signed [ACW-1:0] acc_reg [NUM_PLANES];
    logic signed [DW-1:0]  dist_c [NUM_PLANES];
    logic signed [DW-1:0]  rs, rneg;
    logic [NUM_PLANES-1:0] rej_c, touch_c, rej_reg, touch_reg;
    logic [1:0]            verdict_reg;
    logic                  degen_reg;

    assign cfg_hit = cfg_write && (cfg_index < REG_INDEX_W'(NUM_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= MAT_RESET;
        else if (cfg_hit)
            mat_reg[cfg_index[2:0]] <= cfg_data;
    end

    vfc_planes #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_planes (
        .clk    (clk),
        .rst_n  (rst_n),
        .restart(cfg_hit),
        .mat    (mat_reg),
        .status (status),
        .coef   (coef)
    );

    // whole pipe advances unless a finished result is held
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = status.busy || !en;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ext_max = (extent_x > extent_y) ? extent_x : extent_y;
        if (extent_z > ext_max)
            ext_max = extent_z;
        case (func)
            FUNC_SPHERE: r_in = radius;
            FUNC_BOX:    r_in = ext_max;
            default:     r_in = '0;
        endcase
    end

    // split coefficient into signed high and unsigned low halves
    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_c[p][k] = $signed(coef[p][k][AW-1:LW]) * pt1_reg[k];
                pl_c[p][k] = $signed({1'b0, coef[p][k][LW-1:0]}) * pt1_reg[k];
            end
        end
    end

    always_comb
    begin
        rs   = DW'($signed({1'b0, r4_reg}));
        rneg = -rs;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            dist_c[p] = DW'(acc_reg[p] >>> FRACTION_BITS) + DW'($signed(coef[p][3]));
            if (point4_reg)
            begin
                rej_c[p]   = status.ok[p] && (dist_c[p] < 0);
                touch_c[p] = 1'b0;
            end
            else
            begin
                rej_c[p]   = status.ok[p] && (dist_c[p] < rneg);
                touch_c[p] = status.ok[p] && !(dist_c[p] < rneg) && (dist_c[p] < rs);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg[0] <= center_x;
            pt1_reg[1] <= center_y;
            pt1_reg[2] <= center_z;
            point1_reg <= (func != FUNC_SPHERE) && (func != FUNC_BOX);
            r1_reg     <= r_in;

            ph_reg     <= ph_c;
            pl_reg     <= pl_c;
            point2_reg <= point1_reg;
            r2_reg     <= r1_reg;

            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[p][k] <= (PW'(ph_reg[p][k]) <<< LW) + PW'(pl_reg[p][k]);
            end
            point3_reg <= point2_reg;
            r3_reg     <= r2_reg;

            for (int p = 0; p < NUM_PLANES; p++)
                acc_reg[p] <= ACW'(prod_reg[p][0]) + ACW'(prod_reg[p][1])
                            + ACW'(prod_reg[p][2]);
            point4_reg <= point3_reg;
            r4_reg     <= r3_reg;

            rej_reg   <= rej_c;
            touch_reg <= touch_c;

            if (|rej_reg)
                verdict_reg <= VERDICT_OUTSIDE;
            else if (|touch_reg)
                verdict_reg <= VERDICT_INTERSECT;
            else
                verdict_reg <= VERDICT_INSIDE;
            degen_reg <= |(~status.ok);
        end
    end

    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;
    assign degenerate = degen_reg;

    // a result appears only from an occupied last stage
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v5_reg))
        else $error("result without a transaction in the last stage");

    // no transaction enters while the planes are being recomputed
    a_busy_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy && en |=> !v1_reg)
        else $error("transaction entered during plane recompute");

    // verdict code is one of the three defined codes
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (verdict_reg == VERDICT_OUTSIDE || verdict_reg == VERDICT_INTERSECT
                           || verdict_reg == VERDICT_INSIDE))
        else $error("undefined verdict code");

endmodule

`default_nettype wire
